// ===== hdl/bale_pkg.sv =====
`timescale 1ns / 1ps
// Package with shared constants and types for the bounded array list engine.
package bale_pkg;
    localparam int CAPACITY_DEF = 128;

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_REMOVE = 3'd4,
        CMD_READ   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WORK  = 2'd1,
        ST_DONE  = 2'd2
    } t_state;

    // Operation broadcast to every cell for one cycle.
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_SHUP   = 3'd2,
        OP_SHDN   = 3'd3,
        OP_SQUEEZE = 3'd4
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] key;
        logic [31:0] payload;
    } t_bcast;
endpackage

// ===== hdl/bale_cell.sv =====
`timescale 1ns / 1ps
// One list cell: holds an entry and moves it to or from its neighbors.
module bale_cell (
    input  logic             i_clk,
    input  bale_pkg::t_bcast i_bc,
    input  logic             i_sel,      // Cell index is the target position.
    input  logic             i_above,    // Cell index lies above the target.
    input  logic             i_kill_lo,  // Some lower cell is squeezed out.
    input  logic [31:0]      i_lo_key,
    input  logic [31:0]      i_lo_pay,
    input  logic [31:0]      i_hi_key,
    input  logic [31:0]      i_hi_pay,
    output logic [31:0]      o_key,
    output logic [31:0]      o_pay,
    output logic             o_match
);
    logic [31:0] r_key, r_pay;

    assign o_key   = r_key;
    assign o_pay   = r_pay;
    assign o_match = (r_key == i_bc.key);

    // Each cell picks its next entry from itself, a neighbor or the request.
    always_ff @(posedge i_clk) begin
        case (i_bc.op)
            bale_pkg::OP_LOAD: begin
                if (i_sel) begin
                    r_key <= i_bc.key;
                    r_pay <= i_bc.payload;
                end
            end
            bale_pkg::OP_SHUP: begin
                if (i_sel) begin
                    r_key <= i_bc.key;
                    r_pay <= i_bc.payload;
                end else if (i_above) begin
                    r_key <= i_lo_key;
                    r_pay <= i_lo_pay;
                end
            end
            bale_pkg::OP_SHDN, bale_pkg::OP_SQUEEZE: begin
                if (i_sel || i_above || i_kill_lo) begin
                    r_key <= i_hi_key;
                    r_pay <= i_hi_pay;
                end
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== hdl/bounded_array_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Top level of the bounded array list engine: control and row of cells.
// Append, search, insert, remove and read go from idle through the working
// state to the done state, which raises the strobe; delete by key adds one
// squeeze pass per match through the cell row. A new request may start the
// cycle after the strobe. Reset (synchronous, active low) empties the list;
// cell contents are left as they are. The receiver cannot stall.
module bounded_array_list_engine_unit #(
    parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic signed [31:0] i_key,
    input  logic [31:0] i_payload,
    input  logic [7:0]  i_position,
    output logic        o_valid,
    output logic        o_status,
    output logic signed [31:0] o_out_key,
    output logic [31:0] o_out_payload,
    output logic [7:0]  o_length,
    output logic        o_is_full,
    output logic        o_is_empty
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    bale_pkg::t_state r_state, n_state;
    logic [2:0]  r_cmd;
    logic [31:0] r_key, r_pay;
    logic [7:0]  r_pos;
    logic [CW-1:0] r_cnt, n_cnt;
    logic        r_hit, n_hit;
    logic        r_valid, n_valid;
    logic        r_status, n_status;
    logic [31:0] r_okey, n_okey, r_opay, n_opay;

    bale_pkg::t_bcast bc;
    logic [IW-1:0] tgt;
    logic [CAPACITY-1:0] match, lowm, found;
    logic [31:0] ck [CAPACITY];
    logic [31:0] cp [CAPACITY];
    logic        anym;
    logic [IW-1:0] fidx;
    logic        fany;

    logic        full, pos_ok;
    assign full   = (r_cnt == CW'(CAPACITY));
    assign pos_ok = (r_pos != 8'd0) && (32'(r_pos) <= 32'(r_cnt));

    // Matches limited to live entries.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            lowm[i] = (CW'(i) < r_cnt) && match[i];
        end
    end
    assign anym = |lowm;
    // The lowest live match is one-hot isolated.
    assign found = lowm & (~lowm + 1'b1);
    always_comb begin
        fidx = '0;
        fany = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (found[i]) begin
                fidx = IW'(i);
                fany = 1'b1;
            end
        end
    end

    // Row of cells.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic kill_lo;
            if (g == 0) begin : g_lo0
                assign kill_lo = 1'b0;
            end else begin : g_lon
                assign kill_lo = (bc.op == bale_pkg::OP_SQUEEZE) && (|found[g-1:0]);
            end
            bale_cell u_cell (
                .i_clk    (i_clk),
                .i_bc     (bc),
                .i_sel    ((bc.op != bale_pkg::OP_SQUEEZE) && (tgt == IW'(g))
                           || (bc.op == bale_pkg::OP_SQUEEZE) && found[g]),
                .i_above  ((bc.op != bale_pkg::OP_SQUEEZE) && (IW'(g) > tgt)),
                .i_kill_lo(kill_lo),
                .i_lo_key ((g == 0) ? 32'd0 : ck[(g == 0) ? 0 : g-1]),
                .i_lo_pay ((g == 0) ? 32'd0 : cp[(g == 0) ? 0 : g-1]),
                .i_hi_key ((g == CAPACITY-1) ? 32'd0 : ck[(g == CAPACITY-1) ? g : g+1]),
                .i_hi_pay ((g == CAPACITY-1) ? 32'd0 : cp[(g == CAPACITY-1) ? g : g+1]),
                .o_key    (ck[g]),
                .o_pay    (cp[g]),
                .o_match  (match[g])
            );
        end
    endgenerate

    assign busy          = (r_state != bale_pkg::ST_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_key     = r_okey;
    assign o_out_payload = r_opay;
    assign o_length      = 8'(r_cnt);
    assign o_is_full     = full;
    assign o_is_empty    = (r_cnt == '0);

    // Sequencer: each request passes through the working state; delete stays there for one squeeze pass per match.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_hit    = r_hit;
        n_valid  = 1'b0;
        n_status = r_status;
        n_okey   = r_okey;
        n_opay   = r_opay;
        bc.op    = bale_pkg::OP_NONE;
        bc.key   = r_key;
        bc.payload = r_pay;
        tgt      = '0;
        case (r_state)
            bale_pkg::ST_IDLE: begin
                n_hit = 1'b0;
                if (start) begin
                    n_state = bale_pkg::ST_WORK;
                end
            end
            bale_pkg::ST_WORK: begin
                n_state  = bale_pkg::ST_DONE;
                n_status = 1'b1;
                n_okey   = '0;
                n_opay   = '0;
                case (r_cmd)
                    bale_pkg::CMD_APPEND: begin
                        if (!full) begin
                            bc.op = bale_pkg::OP_LOAD;
                            tgt = IW'(r_cnt);
                            n_cnt = r_cnt + 1'b1;
                            n_status = 1'b0;
                        end
                    end
                    bale_pkg::CMD_DELETE: begin
                        n_status = !(r_hit || anym);
                        if (anym) begin
                            bc.op = bale_pkg::OP_SQUEEZE;
                            n_cnt = r_cnt - 1'b1;
                            n_hit = 1'b1;
                            n_state = bale_pkg::ST_WORK;
                        end
                    end
                    bale_pkg::CMD_SEARCH: begin
                        if (fany) begin
                            n_status = 1'b0;
                            n_okey = ck[fidx];
                            n_opay = cp[fidx];
                        end
                    end
                    bale_pkg::CMD_INSERT: begin
                        if (!full && r_pos != 8'd0) begin
                            n_cnt = r_cnt + 1'b1;
                            n_status = 1'b0;
                            if (32'(r_pos) > 32'(r_cnt)) begin
                                bc.op = bale_pkg::OP_LOAD;
                                tgt = IW'(r_cnt);
                            end else begin
                                bc.op = bale_pkg::OP_SHUP;
                                tgt = IW'(r_pos - 8'd1);
                            end
                        end
                    end
                    bale_pkg::CMD_REMOVE: begin
                        if (pos_ok) begin
                            bc.op = bale_pkg::OP_SHDN;
                            tgt = IW'(r_pos - 8'd1);
                            n_cnt = r_cnt - 1'b1;
                            n_status = 1'b0;
                        end
                    end
                    bale_pkg::CMD_READ: begin
                        if (pos_ok) begin
                            n_status = 1'b0;
                            n_okey = ck[IW'(r_pos - 8'd1)];
                            n_opay = cp[IW'(r_pos - 8'd1)];
                        end
                    end
                    default: begin
                    end
                endcase
                if (n_state == bale_pkg::ST_DONE) begin
                    n_valid = 1'b1;
                end
            end
            bale_pkg::ST_DONE: begin
                n_state = bale_pkg::ST_IDLE;
            end
            default: begin
                n_state = bale_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bale_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
            r_hit   <= n_hit;
        end
    end

    // Request capture and result registers.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
            r_pay <= i_payload;
            r_pos <= i_position;
        end
        r_status <= n_status;
        r_okey   <= n_okey;
        r_opay   <= n_opay;
    end

    // The entry count never exceeds the capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY)) else $error("entry count above capacity");
    // A strobe is only raised while a request is in flight.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> busy) else $error("strobe without request");
    // A started request yields the working state next.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == bale_pkg::ST_WORK))
        else $error("request not taken");
endmodule
